FILE: rtl/cbe_pkg.sv
package cbe_pkg;

  localparam int UNIT_X_W  = 19;
  localparam int CURVE_Y_W = 20;
  localparam int CTRL_W    = 20;
  localparam int TOL_W     = 17;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 5;

  localparam logic signed [CTRL_W-1:0] CTRL1_X_RST = 20'sd0;
  localparam logic signed [CTRL_W-1:0] CTRL1_Y_RST = 20'sd0;
  localparam logic signed [CTRL_W-1:0] CTRL2_X_RST = 20'sd65536;
  localparam logic signed [CTRL_W-1:0] CTRL2_Y_RST = 20'sd65536;
  localparam logic [TOL_W-1:0]         TOL_RST     = 17'd16;

  localparam logic signed [CURVE_Y_W-1:0] Y_MAX = 20'sh7FFFF;
  localparam logic signed [CURVE_Y_W-1:0] Y_MIN = 20'sh80000;

  // horner stage index: 0 adds c2, 1 adds c1, 2 is the last product
  localparam logic [1:0] STAGE_C2   = 2'd0;
  localparam logic [1:0] STAGE_C1   = 2'd1;
  localparam logic [1:0] STAGE_LAST = 2'd2;

  typedef enum logic [2:0] {
    REG_CTRL1_X,
    REG_CTRL1_Y,
    REG_CTRL2_X,
    REG_CTRL2_Y,
    REG_TOLERANCE
  } cbe_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MID,
    ST_MUL,
    ST_ADD,
    ST_CHECK,
    ST_YSTART,
    ST_FIN
  } cbe_state_e;

  typedef struct packed {
    logic signed [CTRL_W-1:0] ctrl1_x;
    logic signed [CTRL_W-1:0] ctrl1_y;
    logic signed [CTRL_W-1:0] ctrl2_x;
    logic signed [CTRL_W-1:0] ctrl2_y;
    logic [TOL_W-1:0]         tolerance;
  } cbe_cfg_t;

  typedef struct packed {
    logic       load;
    logic       mid;
    logic       mul;
    logic       add;
    logic       check;
    logic       start_y;
    logic       capture;
    logic       sel_y;
    logic [1:0] stage;
  } cbe_cmd_t;

  typedef struct packed {
    logic in_tol;
  } cbe_status_t;

endpackage

FILE: rtl/cbe_in_if.sv
interface cbe_in_if import cbe_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [UNIT_X_W-1:0]  unit_x;

  modport source (output valid, output unit_x, input ready);
  modport sink   (input valid, input unit_x, output ready);
endinterface

FILE: rtl/cbe_out_if.sv
interface cbe_out_if import cbe_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [CURVE_Y_W-1:0] curve_y;
  logic                        converged;

  modport source (output valid, output curve_y, output converged, input ready);
  modport sink   (input valid, input curve_y, input converged, output ready);
endinterface

FILE: rtl/cbe_regs.sv
module cbe_regs import cbe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cbe_cfg_t          cfg_o
);

  cbe_cfg_t cfg_q, cfg_d;
  cbe_reg_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = cbe_reg_e'(paddr[APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_CTRL1_X:   cfg_d.ctrl1_x   = pwdata[CTRL_W-1:0];
        REG_CTRL1_Y:   cfg_d.ctrl1_y   = pwdata[CTRL_W-1:0];
        REG_CTRL2_X:   cfg_d.ctrl2_x   = pwdata[CTRL_W-1:0];
        REG_CTRL2_Y:   cfg_d.ctrl2_y   = pwdata[CTRL_W-1:0];
        REG_TOLERANCE: cfg_d.tolerance = pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CTRL1_X:   prdata = {{(APB_DW-CTRL_W){1'b0}}, cfg_q.ctrl1_x};
      REG_CTRL1_Y:   prdata = {{(APB_DW-CTRL_W){1'b0}}, cfg_q.ctrl1_y};
      REG_CTRL2_X:   prdata = {{(APB_DW-CTRL_W){1'b0}}, cfg_q.ctrl2_x};
      REG_CTRL2_Y:   prdata = {{(APB_DW-CTRL_W){1'b0}}, cfg_q.ctrl2_y};
      REG_TOLERANCE: prdata = {{(APB_DW-TOL_W){1'b0}}, cfg_q.tolerance};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ctrl1_x   <= CTRL1_X_RST;
      cfg_q.ctrl1_y   <= CTRL1_Y_RST;
      cfg_q.ctrl2_x   <= CTRL2_X_RST;
      cfg_q.ctrl2_y   <= CTRL2_Y_RST;
      cfg_q.tolerance <= TOL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/cbe_ctrl.sv
module cbe_ctrl import cbe_pkg::*; #(
  parameter int MAX_STEPS = 17
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  cbe_status_t status_i,
  output cbe_cmd_t    cmd_o
);

  localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam logic [SW-1:0] STEP_LAST = SW'(MAX_STEPS - 1);

  cbe_state_e    state_q, state_d;
  logic [1:0]    stage_q, stage_d;
  logic [SW-1:0] step_q, step_d;
  logic          ph_y_q, ph_y_d;
  logic          out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    stage_d    = stage_q;
    step_d     = step_q;
    ph_y_d     = ph_y_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          ph_y_d     = 1'b0;
          state_d    = ST_MID;
        end
      end
      ST_MID: begin
        cmd_o.mid = 1'b1;
        stage_d   = STAGE_C2;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add   = 1'b1;
        cmd_o.stage = stage_q;
        cmd_o.sel_y = ph_y_q;
        if (stage_q == STAGE_LAST) begin
          state_d = ph_y_q ? ST_FIN : ST_CHECK;
        end else begin
          stage_d = stage_q + 2'd1;
          state_d = ST_MUL;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (status_i.in_tol || step_q == STEP_LAST) begin
          state_d = ST_YSTART;
        end else begin
          step_d  = step_q + SW'(1);
          state_d = ST_MID;
        end
      end
      ST_YSTART: begin
        cmd_o.start_y = 1'b1;
        ph_y_d        = 1'b1;
        stage_d       = STAGE_C2;
        state_d       = ST_MUL;
      end
      ST_FIN: begin
        // output register free or emptied in this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.capture) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      stage_q     <= STAGE_C2;
      step_q      <= '0;
      ph_y_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_q     <= stage_d;
      step_q      <= step_d;
      ph_y_q      <= ph_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/cbe_dpath.sv
module cbe_dpath import cbe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  cbe_cmd_t                    cmd_i,
  input  cbe_cfg_t                    cfg_i,
  input  logic signed [UNIT_X_W-1:0]  unit_x_i,
  output cbe_status_t                 status_o,
  output logic signed [CURVE_Y_W-1:0] curve_y_o,
  output logic                        converged_o
);

  localparam int DW = ((FRAC_BITS > 20) ? FRAC_BITS : 20) + 6;
  localparam int TW = FRAC_BITS + 1;
  localparam int PW = DW + TW + 1;
  localparam logic signed [DW-1:0] ONE   = DW'(1) << FRAC_BITS;
  localparam logic [TW-1:0]        T_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] HALF  = PW'(1) << (FRAC_BITS - 1);

  function automatic logic signed [DW-1:0] clamp01(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] r;
    r = v;
    if (v < 0) begin
      r = '0;
    end else if (v > ONE) begin
      r = ONE;
    end
    return r;
  endfunction

  logic signed [DW-1:0] target_q;
  logic signed [DW-1:0] c1x_q, c2x_q, c3x_q, c1y_q, c2y_q, c3y_q;
  logic signed [DW-1:0] acc_q;
  logic signed [PW-1:0] prod_q;
  logic [TW-1:0]        lo_q, hi_q, t_q;
  logic                 conv_q;
  logic signed [CURVE_Y_W-1:0] curve_y_q;
  logic                 converged_q;

  logic signed [DW-1:0] ax3, bx3, ay3, by3, xa, xb, ya, yb;
  logic [TW:0]          mid_sum;
  logic signed [PW-1:0] prod_d, rnd_full;
  logic signed [DW-1:0] coef, acc_next;
  logic signed [DW:0]   err;
  logic [DW:0]          err_abs;
  logic                 in_tol;

  // coefficients from config, 3*v formed as v + 2v
  always_comb begin
    xa  = clamp01(DW'($signed(cfg_i.ctrl1_x)));
    xb  = clamp01(DW'($signed(cfg_i.ctrl2_x)));
    ya  = DW'($signed(cfg_i.ctrl1_y));
    yb  = DW'($signed(cfg_i.ctrl2_y));
    ax3 = xa + (xa <<< 1);
    bx3 = xb + (xb <<< 1);
    ay3 = ya + (ya <<< 1);
    by3 = yb + (yb <<< 1);
  end

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign prod_d   = PW'(acc_q) * PW'($signed({1'b0, t_q}));
  assign rnd_full = (prod_q + HALF) >>> FRAC_BITS;

  always_comb begin
    case (cmd_i.stage)
      STAGE_C2: coef = cmd_i.sel_y ? c2y_q : c2x_q;
      STAGE_C1: coef = cmd_i.sel_y ? c1y_q : c1x_q;
      default:  coef = '0;
    endcase
  end

  assign acc_next = DW'(rnd_full) + coef;

  assign err     = (DW+1)'(acc_q) - (DW+1)'(target_q);
  assign err_abs = (err < 0) ? (DW+1)'(-err) : (DW+1)'(err);
  assign in_tol  = err_abs <= (DW+1)'(cfg_i.tolerance);
  assign status_o.in_tol = in_tol;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= clamp01(DW'(unit_x_i));
      c1x_q    <= ax3;
      c2x_q    <= bx3 - (ax3 <<< 1);
      c3x_q    <= ax3 - bx3 + ONE;
      c1y_q    <= ay3;
      c2y_q    <= by3 - (ay3 <<< 1);
      c3y_q    <= ay3 - by3 + ONE;
      lo_q     <= '0;
      hi_q     <= T_ONE;
    end
    if (cmd_i.mid) begin
      t_q   <= mid_sum[TW:1];
      acc_q <= c3x_q;
    end
    if (cmd_i.start_y) begin
      acc_q <= c3y_q;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    if (cmd_i.add) begin
      acc_q <= acc_next;
    end
    if (cmd_i.check) begin
      conv_q <= in_tol;
      if (!in_tol) begin
        if (acc_q < target_q) begin
          lo_q <= t_q;
        end else begin
          hi_q <= t_q;
        end
      end
    end
    if (cmd_i.capture) begin
      converged_q <= conv_q;
      if (acc_q > DW'(Y_MAX)) begin
        curve_y_q <= Y_MAX;
      end else if (acc_q < DW'(Y_MIN)) begin
        curve_y_q <= Y_MIN;
      end else begin
        curve_y_q <= acc_q[CURVE_Y_W-1:0];
      end
    end
  end

  assign curve_y_o   = curve_y_q;
  assign converged_o = converged_q;

endmodule

FILE: rtl/cubic_bezier_easing_eval.sv
// sequence: load on input transfer, then n bisection steps (midpoint, horner in x, tolerance check),
// n in 1..MAX_STEPS, then horner in y and capture into the output register
// one shared multiplier, three multiplies per horner evaluation
// one item in flight
// next input taken while the result waits in the output register
// reset: control and state machine clear, config registers return to their reset values
module cubic_bezier_easing_eval import cbe_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int MAX_STEPS = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  cbe_in_if.sink            in_i,
  cbe_out_if.source         out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cbe_cfg_t    cfg;
  cbe_cmd_t    cmd;
  cbe_status_t status;
  logic        in_ready;
  logic        out_valid;

  cbe_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cbe_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cbe_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .unit_x_i    (in_i.unit_x),
    .status_o    (status),
    .curve_y_o   (out_o.curve_y),
    .converged_o (out_o.converged)
  );

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule

FILE: test/tb_cubic_bezier_easing_eval.sv
module tb_cubic_bezier_easing_eval;
  import cbe_pkg::*;

  localparam int FRAC_BITS      = 16;
  localparam int MAX_STEPS      = 17;
  localparam longint FIX_ONE    = 64'sd1 <<< FRAC_BITS;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 600;
  localparam int DRAIN_CYCLES   = 160;

  typedef struct {
    logic [UNIT_X_W-1:0]         unit_x;
    logic signed [CURVE_Y_W-1:0] curve_y;
    logic                        converged;
  } curve_res_t;

  logic clk_i;
  logic rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  cbe_in_if  in_if ();
  cbe_out_if out_if ();

  cbe_cfg_t                   cfg_model;
  logic [UNIT_X_W-1:0]        pending_x_q[$];
  curve_res_t                 exp_curve_q[$];
  int unsigned                n_errors;
  int unsigned                n_results;
  int unsigned                tx_gap, tx_calm;
  int unsigned                rx_stall, rx_calm;
  int unsigned                idle_cycles;

  cubic_bezier_easing_eval #(
    .FRAC_BITS(FRAC_BITS),
    .MAX_STEPS(MAX_STEPS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clamp_q(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // product rounded half up, arithmetic shift gives the floor
  function automatic longint fix_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint horner(longint c1, longint c2, longint c3, longint t);
    return fix_mul(fix_mul(fix_mul(c3, t) + c2, t) + c1, t);
  endfunction

  function automatic curve_res_t eval_easing(logic [UNIT_X_W-1:0] ux);
    longint     target, ax, bx, ay, by, lo, hi, t, xv, err, yv;
    bit         hit;
    int         k;
    curve_res_t r;
    target = clamp_q(longint'($signed(ux)), 0, FIX_ONE);
    ax = 3 * clamp_q(longint'($signed(cfg_model.ctrl1_x)), 0, FIX_ONE);
    bx = 3 * clamp_q(longint'($signed(cfg_model.ctrl2_x)), 0, FIX_ONE);
    ay = 3 * longint'($signed(cfg_model.ctrl1_y));
    by = 3 * longint'($signed(cfg_model.ctrl2_y));
    lo = 0;
    hi = FIX_ONE;
    t = 0;
    hit = 1'b0;
    for (k = 0; k < MAX_STEPS && !hit; k++) begin
      t = (lo + hi) >>> 1;
      xv = horner(ax, bx - 2 * ax, ax - bx + FIX_ONE, t);
      err = (xv < target) ? target - xv : xv - target;
      if (err <= longint'(cfg_model.tolerance)) hit = 1'b1;
      else if (xv < target) lo = t;
      else hi = t;
    end
    yv = horner(ay, by - 2 * ay, ay - by + FIX_ONE, t);
    yv = clamp_q(yv, longint'(Y_MIN), longint'(Y_MAX));
    r.unit_x    = ux;
    r.curve_y   = yv[CURVE_Y_W-1:0];
    r.converged = hit;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(16, 4);
    return $urandom_range(80, 30);
  endfunction

  function automatic logic [UNIT_X_W-1:0] rand_unit_x();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 70) return UNIT_X_W'($urandom_range(65536, 0));
    if (sel < 80) begin
      if ($urandom_range(1)) return UNIT_X_W'($urandom_range(16, 0));
      return UNIT_X_W'(65536 - $urandom_range(16, 0));
    end
    if (sel < 95) return UNIT_X_W'($urandom());
    return $urandom_range(1) ? 19'h40000 : 19'h3FFFF;
  endfunction

  function automatic logic [APB_DW-1:0] rand_ctrl();
    int v;
    if ($urandom_range(99) < 75) v = int'($urandom_range(65536, 0));
    else v = int'($urandom_range(524288, 0)) - 262144;
    // upper bits are not part of the register
    return ($urandom() & 32'hFFF0_0000) | (32'(v) & 32'h000F_FFFF);
  endfunction

  function automatic logic [APB_DW-1:0] rand_tol();
    int unsigned sel;
    logic [APB_DW-1:0] v;
    sel = $urandom_range(99);
    if (sel < 10) v = 0;
    else if (sel < 70) v = $urandom_range(64, 1);
    else if (sel < 80) v = 65536;
    else v = $urandom_range(32'h1FFFF, 0);
    return ($urandom() & 32'hFFFE_0000) | v;
  endfunction

  task automatic report_mismatch(string what, curve_res_t e, longint exp_v, longint got_v);
    $display("mismatch %s: unit_x=%0d expected %0d got %0d", what,
             $signed(e.unit_x), exp_v, got_v);
    n_errors++;
  endtask

  task automatic apb_write(logic [2:0] idx, logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_CTRL1_X:   cfg_model.ctrl1_x   = data[CTRL_W-1:0];
      REG_CTRL1_Y:   cfg_model.ctrl1_y   = data[CTRL_W-1:0];
      REG_CTRL2_X:   cfg_model.ctrl2_x   = data[CTRL_W-1:0];
      REG_CTRL2_Y:   cfg_model.ctrl2_y   = data[CTRL_W-1:0];
      REG_TOLERANCE: cfg_model.tolerance = data[TOL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_curve(logic [APB_DW-1:0] c1x, logic [APB_DW-1:0] c1y,
                           logic [APB_DW-1:0] c2x, logic [APB_DW-1:0] c2y,
                           logic [APB_DW-1:0] tol);
    apb_write(REG_CTRL1_X, c1x);
    apb_write(REG_CTRL1_Y, c1y);
    apb_write(REG_CTRL2_X, c2x);
    apb_write(REG_CTRL2_Y, c2y);
    apb_write(REG_TOLERANCE, tol);
  endtask

  task automatic push_directed();
    logic [UNIT_X_W-1:0] pts[12];
    pts = '{19'd0, 19'd1, 19'd32768, 19'd65535, 19'd65536, 19'd65537,
            19'h7FFFF, 19'h40000, 19'h3FFFF, 19'd131072, 19'h60000, 19'd21845};
    foreach (pts[i]) pending_x_q.push_back(pts[i]);
  endtask

  task automatic push_random(int unsigned n);
    @(negedge clk_i);
    repeat (n) pending_x_q.push_back(rand_unit_x());
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_x_q.size() != 0 || in_if.valid || exp_curve_q.size() != 0)
      @(negedge clk_i);
  endtask

  // sender: offers one item at a time, random gaps between transfers except in calm stretches
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid  <= 1'b0;
      in_if.unit_x <= '0;
      tx_gap       <= 0;
      tx_calm      <= 0;
    end else begin
      if (in_if.valid && in_if.ready) exp_curve_q.push_back(eval_easing(in_if.unit_x));
      if (!in_if.valid || in_if.ready) begin
        if (tx_gap != 0) begin
          in_if.valid <= 1'b0;
          tx_gap      <= tx_gap - 1;
        end else if (pending_x_q.size() != 0) begin
          in_if.valid  <= 1'b1;
          in_if.unit_x <= pending_x_q.pop_front();
          if (tx_calm != 0) tx_calm <= tx_calm - 1;
          else if ($urandom_range(99) < 4) tx_calm <= $urandom_range(60, 20);
          else tx_gap <= pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each transfer, random stalls and two long hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    curve_res_t e;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_stall     <= 0;
      rx_calm      <= 0;
      n_results    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_results <= n_results + 1;
        if (exp_curve_q.size() == 0) begin
          $display("unexpected result: curve_y=%0d converged=%0d",
                   out_if.curve_y, out_if.converged);
          n_errors++;
        end else begin
          e = exp_curve_q.pop_front();
          if (out_if.curve_y !== e.curve_y)
            report_mismatch("curve_y", e, e.curve_y, out_if.curve_y);
          if (out_if.converged !== e.converged)
            report_mismatch("converged", e, e.converged, out_if.converged);
        end
      end
      if (out_if.valid && out_if.ready && (n_results == 149 || n_results == 499)) begin
        out_if.ready <= 1'b0;
        rx_stall     <= LONG_HOLD;
      end else if (rx_stall != 0) begin
        out_if.ready <= 1'b0;
        rx_stall     <= rx_stall - 1;
      end else if (rx_calm != 0) begin
        out_if.ready <= 1'b1;
        rx_calm      <= rx_calm - 1;
      end else if ($urandom_range(99) < 3) begin
        out_if.ready <= 1'b1;
        rx_calm      <= $urandom_range(150, 50);
      end else begin
        int unsigned g;
        g = pick_gap();
        out_if.ready <= (g == 0);
        if (g != 0) rx_stall <= g - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable && pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.unit_x = '0;
    out_if.ready = 1'b0;
    n_errors     = 0;
    idle_cycles  = 0;
    cfg_model.ctrl1_x   = CTRL1_X_RST;
    cfg_model.ctrl1_y   = CTRL1_Y_RST;
    cfg_model.ctrl2_x   = CTRL2_X_RST;
    cfg_model.ctrl2_y   = CTRL2_Y_RST;
    cfg_model.tolerance = TOL_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset curve is linear: input clamping at both ends and sign bit
    @(negedge clk_i);
    push_directed();
    push_random(60);
    wait_drained();

    set_curve(32'd27525, 32'd0, 32'd38011, 32'd65536, 32'd16);
    push_random(85);
    wait_drained();

    // control x clamped, exact match required so items can run to the step cap
    set_curve(-32'sd262144, 32'd262144, 32'd262144, -32'sd262144, 32'd0);
    @(negedge clk_i);
    push_directed();
    push_random(85);
    wait_drained();

    set_curve(32'd262144, -32'sd262144, -32'sd262144, 32'd262144, 32'd65536);
    push_random(85);
    wait_drained();

    // unused register slots must not disturb the curve
    set_curve(32'd65536, 32'hFFF4_0000, 32'd0, 32'h0003_FFFF, 32'hFFFF_FFFF);
    for (int i = int'(REG_TOLERANCE) + 1; i < 8; i++) apb_write(3'(i), $urandom());
    push_random(85);
    wait_drained();

    repeat (5) begin
      set_curve(rand_ctrl(), rand_ctrl(), rand_ctrl(), rand_ctrl(), rand_tol());
      push_random(85);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && exp_curve_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
